// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the value-noise RTL.
// Users must have clk and arst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define VNG_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define VNG_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/vng_pkg.sv =====
// Value-noise generator package: widths, hash constants, octave table, stage enables.
// No dependencies; imported by every module of the block.
package vng_pkg;

	// grid is square: width and height are both GRID_SIZE
	localparam int GRID_SIZE   = 512;
	localparam int FRAC_W      = $clog2(GRID_SIZE);
	localparam int COORD_W     = 9;
	localparam int FREQ_W      = 4;
	localparam int SCALED_W    = COORD_W + FREQ_W;
	localparam int CELL_W      = SCALED_W - FRAC_W;
	localparam int CORNER_W    = CELL_W + 1;

	localparam int NUM_OCT     = 3;
	localparam int NUM_CORNER  = 4;
	localparam logic [FREQ_W-1:0] OCT_FREQ [NUM_OCT] = '{4'd3, 4'd7, 4'd15};

	// smoothstep weight Q0.27, corner value Q0.32 with one carry bit
	localparam int U_W         = 27;
	localparam int CQ_W        = 33;

	localparam int HASH_W      = 32;
	localparam int H_W         = 16;
	localparam logic [HASH_W-1:0] HASH_KX  = 32'd1619;
	localparam logic [HASH_W-1:0] HASH_KZ  = 32'd31337;
	localparam logic [HASH_W-1:0] HASH_KS  = 32'd6971;
	localparam logic [HASH_W-1:0] HASH_MIX = 32'h045d_9f3b;

	localparam int SEED_W      = 32;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_W       = 8;

	// remap keeps every result inside this band
	localparam logic [OUT_W-1:0] OUT_MIN = 8'd51;
	localparam logic [OUT_W-1:0] OUT_MAX = 8'd204;

	localparam int STAGES      = 8;
	typedef logic [STAGES:1] stage_en_t;

endpackage

// ===== rtl/core/value_noise_pixel_generator_top.sv =====
// channel | dir | payload (low bit first)              | accepted when
// s_axis  | in  | pixel_x[8:0], pixel_z[17:9], pad     | s_axis_tvalid & s_axis_tready
// m_axis  | out | noise_value[7:0]                     | m_axis_tvalid & m_axis_tready
// cfg     | in  | seed[31:0]                           | cfg_we
//
// Three-octave 2-D value-noise pixel generator, top level.
// Depends on vng_pkg, vng_weight, vng_hash, vng_blend, vng_remap, assert_macros.svh.
//
// One pixel per clock while m_axis_tready does not stall the pipe, through eight stages:
//   scale, three for hash and smoothstep, two for the blend, two for octave sum and
//   remap. m_axis_tvalid is the valid bit of the eighth stage.
// Reset clears the stage valid bits and the seed (to zero); datapath flops are not reset.
// Stalls: each stage loads when it is empty or the next stage loads, so bubbles
//   are squeezed out; s_axis_tready drops only while all eight stages hold a word
//   and m_axis_tready is low.
// Seed writes are registered and are only expected while the pipe is empty.
module value_noise_pixel_generator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [vng_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [8:0] pixel_x, [17:9] pixel_z, [23:18] zero
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [vng_pkg::OUT_W-1:0]       m_axis_tdata,   // [7:0] noise_value
	input  logic                            cfg_we,
	input  logic [vng_pkg::SEED_W-1:0]      cfg_wdata       // [31:0] seed
);
	import vng_pkg::*;
	`include "assert_macros.svh"

	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_z;
	logic [HASH_W-1:0]  seed_mul_q;     // seed * 6971, the only form the hash needs
	logic [STAGES:1]    vld_q;
	logic [STAGES:1]    vld_in;
	stage_en_t          stage_en;
	logic [CQ_W-1:0]    oct_s6 [NUM_OCT];
	logic [OUT_W-1:0]   noise_s8;

	assign pixel_x = s_axis_tdata[COORD_W-1:0];
	assign pixel_z = s_axis_tdata[2*COORD_W-1:COORD_W];

	// ---------------- config ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_mul_q <= '0;
		end else if (cfg_we) begin
			seed_mul_q <= cfg_wdata * HASH_KS;
		end
	end

	// ---------------- flow control ----------------
	// stage k loads when empty or when stage k+1 loads; output side closes the chain
	always_comb begin
		stage_en[STAGES] = ~vld_q[STAGES] | m_axis_tready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			stage_en[k] = ~vld_q[k] | stage_en[k+1];
		end
	end

	assign vld_in = {vld_q[STAGES-1:1], s_axis_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_in & stage_en) | (vld_q & ~stage_en);
		end
	end

	assign s_axis_tready = stage_en[1];
	assign m_axis_tvalid = vld_q[STAGES];

	// ---------------- per-octave datapath ----------------
	for (genvar k = 0; k < NUM_OCT; k++) begin : g_oct
		logic [SCALED_W-1:0] sx;
		logic [SCALED_W-1:0] sz;
		logic [CELL_W-1:0]   ix_s1;
		logic [CELL_W-1:0]   iz_s1;
		logic [FRAC_W-1:0]   rx_s1;
		logic [FRAC_W-1:0]   rz_s1;
		logic [HASH_W-1:0]   smul;
		logic [U_W-1:0]      ux_s4;
		logic [U_W-1:0]      uz_s4;
		logic [CQ_W-1:0]     corner_s4 [NUM_CORNER];

		// s1: scale coordinate by octave frequency, split into cell and fraction
		assign sx = SCALED_W'(pixel_x) * SCALED_W'(OCT_FREQ[k]);
		assign sz = SCALED_W'(pixel_z) * SCALED_W'(OCT_FREQ[k]);

		always_ff @(posedge clk) begin
			if (stage_en[1]) begin
				ix_s1 <= sx[SCALED_W-1:FRAC_W];
				iz_s1 <= sz[SCALED_W-1:FRAC_W];
				rx_s1 <= sx[FRAC_W-1:0];
				rz_s1 <= sz[FRAC_W-1:0];
			end
		end

		// octave seed is seed + k, so its product is seed*6971 + k*6971
		assign smul = seed_mul_q + HASH_W'(k) * HASH_KS;

		vng_weight u_wx (
			.clk (clk),
			.en  (stage_en),
			.r   (rx_s1),
			.u   (ux_s4)
		);

		vng_weight u_wz (
			.clk (clk),
			.en  (stage_en),
			.r   (rz_s1),
			.u   (uz_s4)
		);

		// corner order: (x,z) (x+1,z) (x,z+1) (x+1,z+1)
		for (genvar c = 0; c < NUM_CORNER; c++) begin : g_corner
			logic [CORNER_W-1:0] cx;
			logic [CORNER_W-1:0] cz;

			assign cx = CORNER_W'(ix_s1) + CORNER_W'(c % 2);
			assign cz = CORNER_W'(iz_s1) + CORNER_W'(c / 2);

			vng_hash u_hash (
				.clk    (clk),
				.en     (stage_en),
				.cx     (cx),
				.cz     (cz),
				.smul   (smul),
				.corner (corner_s4[c])
			);
		end

		vng_blend u_blend (
			.clk    (clk),
			.en     (stage_en),
			.corner (corner_s4),
			.ux     (ux_s4),
			.uz     (uz_s4),
			.oct    (oct_s6[k])
		);
	end

	// ---------------- octave sum and remap ----------------
	vng_remap u_remap (
		.clk   (clk),
		.en    (stage_en),
		.oct   (oct_s6),
		.noise (noise_s8)
	);

	assign m_axis_tdata = noise_s8;

	// ---------------- checks ----------------
	// a stage that could not move keeps its word
	`VNG_ASSERT_IMPL(a_stall_keeps, 1'b1, ((($past(vld_q) & ~$past(stage_en)) & ~vld_q) == '0), "stalled stage lost its word")
	// input is refused only when every stage is occupied
	`VNG_ASSERT_IMPL(a_refuse_full, !s_axis_tready, (&vld_q), "input refused while a bubble exists")
	// an accepted pixel always lands in the first stage
	`VNG_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, vld_q[1], "accepted word missing in first stage")
	// remap band: clamp never needed
	`VNG_ASSERT_IMPL(a_out_band, m_axis_tvalid, (m_axis_tdata >= OUT_MIN && m_axis_tdata <= OUT_MAX), "noise byte outside remap band")

endmodule

// ===== rtl/core/vng_hash.sv =====
// Lattice corner hash: multiply-xor mix to a Q0.32 corner value, stages s2..s4.
// Depends on vng_pkg.
module vng_hash (
	input  logic                        clk,
	input  vng_pkg::stage_en_t          en,
	input  logic [vng_pkg::CORNER_W-1:0] cx,
	input  logic [vng_pkg::CORNER_W-1:0] cz,
	input  logic [vng_pkg::HASH_W-1:0]  smul,
	output logic [vng_pkg::CQ_W-1:0]    corner
);
	import vng_pkg::*;

	logic [HASH_W-1:0] v0;
	logic [HASH_W-1:0] v1;
	logic [H_W-1:0]    h;
	logic [HASH_W-1:0] xa_s2;
	logic [H_W-1:0]    y_s3;
	logic [CQ_W-1:0]   corner_s4;

	assign v0 = HASH_W'(cx) * HASH_KX + HASH_W'(cz) * HASH_KZ + smul;
	assign v1 = xa_s2 * HASH_MIX;
	// only the low half of the second product is kept
	assign h  = y_s3 * HASH_MIX[H_W-1:0];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			xa_s2 <= v0 ^ (v0 >> H_W);
		end
		if (en[3]) begin
			y_s3 <= v1[H_W-1:0] ^ v1[HASH_W-1:H_W];
		end
		if (en[4]) begin
			// round(h * 2^32 / 65535) == h * 65537 + h[15]
			corner_s4 <= {1'b0, h, h} + CQ_W'(h[H_W-1]);
		end
	end

	assign corner = corner_s4;

endmodule

// ===== rtl/core/vng_weight.sv =====
// Smoothstep weight u = r^2 * (3W - 2r) in Q0.27, stages s2..s4.
// Depends on vng_pkg.
module vng_weight (
	input  logic                      clk,
	input  vng_pkg::stage_en_t        en,
	input  logic [vng_pkg::FRAC_W-1:0] r,
	output logic [vng_pkg::U_W-1:0]   u
);
	import vng_pkg::*;

	localparam int SQ_W       = 2 * FRAC_W;
	localparam int K_W        = FRAC_W + 2;
	localparam int PROD_W     = SQ_W + K_W;
	localparam int SMOOTH_SHR = 3 * FRAC_W - U_W;

	logic [PROD_W-1:0] prod;
	logic [SQ_W-1:0]   rsq_s2;
	logic [K_W-1:0]    k_s2;
	logic [U_W-1:0]    u_s3;
	logic [U_W-1:0]    u_s4;

	assign prod = PROD_W'(rsq_s2) * PROD_W'(k_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			rsq_s2 <= SQ_W'(r) * SQ_W'(r);
			k_s2   <= K_W'(3 * GRID_SIZE) - K_W'({r, 1'b0});
		end
		if (en[3]) begin
			u_s3 <= U_W'(prod >> SMOOTH_SHR);
		end
		if (en[4]) begin
			u_s4 <= u_s3;
		end
	end

	assign u = u_s4;

endmodule

// ===== rtl/core/vng_blend.sv =====
// Bilinear blend of four corners for one octave: rows in s5, columns in s6.
// Depends on vng_pkg.
module vng_blend (
	input  logic                     clk,
	input  vng_pkg::stage_en_t       en,
	input  logic [vng_pkg::CQ_W-1:0] corner [vng_pkg::NUM_CORNER],
	input  logic [vng_pkg::U_W-1:0]  ux,
	input  logic [vng_pkg::U_W-1:0]  uz,
	output logic [vng_pkg::CQ_W-1:0] oct
);
	import vng_pkg::*;

	localparam int P_W = CQ_W + U_W + 2;
	localparam logic signed [P_W-1:0] RND = P_W'(1) <<< (U_W - 1);

	// (a*(1-u) + b*u) rounded, written as a + (b-a)*u
	function automatic logic [CQ_W-1:0] lerp(
		input logic [CQ_W-1:0] a,
		input logic [CQ_W-1:0] b,
		input logic [U_W-1:0]  w
	);
		logic signed [CQ_W:0]  d;
		logic signed [P_W-1:0] p;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = d * $signed({1'b0, w});
		p = (p + RND) >>> U_W;
		return a + p[CQ_W-1:0];
	endfunction

	logic [CQ_W-1:0] top_s5;
	logic [CQ_W-1:0] bot_s5;
	logic [U_W-1:0]  uz_s5;
	logic [CQ_W-1:0] oct_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			top_s5 <= lerp(corner[0], corner[1], ux);
			bot_s5 <= lerp(corner[2], corner[3], ux);
			uz_s5  <= uz;
		end
		if (en[6]) begin
			oct_s6 <= lerp(top_s5, bot_s5, uz_s5);
		end
	end

	assign oct = oct_s6;

endmodule

// ===== rtl/core/vng_remap.sv =====
// Octave weighting, contrast remap and clamp to the output byte, stages s7..s8.
// Depends on vng_pkg.
module vng_remap (
	input  logic                     clk,
	input  vng_pkg::stage_en_t       en,
	input  logic [vng_pkg::CQ_W-1:0] oct [vng_pkg::NUM_OCT],
	output logic [vng_pkg::OUT_W-1:0] noise
);
	import vng_pkg::*;

	localparam int S_W    = CQ_W + 4;
	localparam int N_W    = S_W + 8;
	localparam int DIV_SH = 33;      // 10 * 2^32 == 5 * 2^33
	localparam int Q_W    = 10;
	localparam int R_SH   = 18;
	localparam int M_W    = Q_W + R_SH;
	localparam int RES_W  = OUT_W + 1;
	localparam logic [S_W-1:0]    W_OCT0 = S_W'(5);
	localparam logic [S_W-1:0]    W_OCT1 = S_W'(3);
	localparam logic [S_W-1:0]    W_OCT2 = S_W'(2);
	localparam logic [N_W-1:0]    GAIN   = N_W'(153);
	localparam logic [N_W-1:0]    BIAS   = N_W'(5) << 32;
	localparam logic [M_W-1:0]    RECIP5 = M_W'(52429);   // 2^18 / 5 rounded up, exact floor for q < 2^10
	localparam logic [RES_W-1:0]  BASE   = RES_W'(51);
	localparam logic [RES_W-1:0]  TOP    = RES_W'(255);

	logic [S_W-1:0]   sum;
	logic [N_W-1:0]   num;
	logic [M_W-1:0]   m;
	logic [RES_W-1:0] res;
	logic [Q_W-1:0]   q_s7;
	logic [OUT_W-1:0] noise_s8;

	assign sum = S_W'(oct[0]) * W_OCT0 + S_W'(oct[1]) * W_OCT1 + S_W'(oct[2]) * W_OCT2;
	assign num = BIAS + N_W'(sum) * GAIN;
	assign m   = M_W'(q_s7) * RECIP5;
	assign res = BASE + RES_W'(m >> R_SH);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			q_s7 <= num[DIV_SH +: Q_W];
		end
		if (en[8]) begin
			noise_s8 <= (res > TOP) ? OUT_W'(TOP) : res[OUT_W-1:0];
		end
	end

	assign noise = noise_s8;

endmodule

// ===== tb/value_noise_pixel_generator_top_tb.sv =====
// Testbench for value_noise_pixel_generator_top: pixel words in, noise bytes out.
// It predicts each byte with its own fixed-point model and checks words in order.
// Depends on vng_pkg and the RTL of the block.
module value_noise_pixel_generator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vng_pkg::*;

	// grid and hash constants, kept here so that the predictor stands on its own
	localparam longint unsigned GRID      = 512;
	localparam logic [31:0]     K_X       = 32'd1619;
	localparam logic [31:0]     K_Z       = 32'd31337;
	localparam logic [31:0]     K_SEED    = 32'd6971;
	localparam logic [31:0]     K_MIX     = 32'h045d_9f3b;
	localparam longint unsigned ONE_Q27   = 64'd1 << 27;
	localparam longint unsigned HALF_Q27  = 64'd1 << 26;
	localparam longint unsigned ONE_Q32   = 64'd1 << 32;

	localparam int PIPE_DEPTH   = 8;       // pipeline stages in the block
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 185;     // per seed phase
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] z;
	} pixel_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;    // [8:0] pixel_x, [17:9] pixel_z, [23:18] zero
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;          // [7:0] noise_value
	logic                  cfg_we        = 1'b0;
	logic [SEED_W-1:0]     cfg_wdata     = '0;    // [31:0] seed

	pixel_t        pixel_queue[$];      // pixels waiting to be driven
	logic [7:0]    expected_noise[$];   // predicted bytes, oldest first
	logic [31:0]   noise_seed = '0;     // predictor copy of the seed register

	int unsigned   cycles;
	int unsigned   pixels_sent;
	int unsigned   bytes_checked;
	int unsigned   errors;
	int unsigned   seeds_used;

	// sender burst/gap state and receiver stall pattern
	int unsigned   burst_left;
	int unsigned   gap_left;
	logic [15:0]   ready_pattern;
	int unsigned   pattern_left;

	value_noise_pixel_generator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// lattice corner: 32-bit wrapping hash, low 16 bits scaled to Q0.32, rounded
	function automatic longint unsigned lattice_corner(logic [31:0] cx, logic [31:0] cz,
			logic [31:0] s);
		logic [31:0]     h;
		longint unsigned low16;
		h = cx * K_X + cz * K_Z + s * K_SEED;
		h = (h ^ (h >> 16)) * K_MIX;
		h = (h ^ (h >> 16)) * K_MIX;
		low16 = longint'(h[15:0]);
		return ((low16 << 32) + 64'd32767) / 64'd65535;
	endfunction

	// smoothstep of r/GRID in Q0.27
	function automatic longint unsigned fade_q27(longint unsigned r);
		longint unsigned num;
		num = r * r * (3 * GRID - 2 * r);
		return (num << 27) / (GRID * GRID * GRID);
	endfunction

	function automatic longint unsigned lerp_q27(longint unsigned a, longint unsigned b,
			longint unsigned u);
		return (a * (ONE_Q27 - u) + b * u + HALF_Q27) >> 27;
	endfunction

	function automatic longint unsigned octave_value(pixel_t p, longint unsigned freq,
			logic [31:0] s);
		longint unsigned sx, sz, ux, uz, top, bot;
		logic [31:0]     ix, iz;
		sx  = longint'(p.x) * freq;
		sz  = longint'(p.z) * freq;
		ix  = 32'(sx / GRID);
		iz  = 32'(sz / GRID);
		ux  = fade_q27(sx % GRID);
		uz  = fade_q27(sz % GRID);
		top = lerp_q27(lattice_corner(ix, iz, s), lattice_corner(ix + 1, iz, s), ux);
		bot = lerp_q27(lattice_corner(ix, iz + 1, s), lattice_corner(ix + 1, iz + 1, s), ux);
		return lerp_q27(top, bot, uz);
	endfunction

	// weighted octave sum (5:3:2), remap 0.5+(v-0.5)*0.6, scale, round, clamp
	function automatic logic [7:0] noise_pixel(pixel_t p, logic [31:0] s);
		longint unsigned total, r;
		total = 5 * octave_value(p, 3, s)
		      + 3 * octave_value(p, 7, s + 32'd1)
		      + 2 * octave_value(p, 15, s + 32'd2);
		r = 51 + (5 * ONE_Q32 + 153 * total) / (10 * ONE_Q32);
		if (r > 255) begin
			r = 255;
		end
		return r[7:0];
	endfunction

	// ---------------------------------------------------------------- driver
	// Bursts of random length, random gaps; a word once raised is held until taken.
	always @(posedge clk or negedge arst_n) begin
		pixel_t p;
		pixel_t cur;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			burst_left    <= 0;
			gap_left      <= 0;
		end else begin
			cur.x = s_axis_tdata[COORD_W-1:0];
			cur.z = s_axis_tdata[2*COORD_W-1:COORD_W];
			if (s_axis_tvalid && s_axis_tready) begin
				expected_noise = {expected_noise, noise_pixel(cur, noise_seed)};
				pixels_sent++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the word
			end else if (gap_left != 0) begin
				gap_left      <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pixel_queue.size() != 0) begin
				p = pixel_queue.pop_front();
				s_axis_tdata  <= {6'd0, p.z, p.x};
				s_axis_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// a quarter of the bursts run straight into the next one
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- receiver
	// Ready follows a rotating 16-bit pattern; a new pattern is picked every so often,
	// sometimes all ones so that long stretches run without stalls.
	always @(posedge clk or negedge arst_n) begin
		logic [15:0] next;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_pattern <= 16'hFFFF;
			pattern_left  <= 0;
		end else begin
			next = {ready_pattern[0], ready_pattern[15:1]};
			if (pattern_left == 0) begin
				case ($urandom_range(0, 3))
					0: next = 16'hFFFF;
					1: next = 16'h00FF;
					default: next = 16'($urandom) | 16'h0001;
				endcase
				pattern_left <= $urandom_range(16, 200);
			end else begin
				pattern_left <= pattern_left - 1;
			end
			ready_pattern <= next;
			m_axis_tready <= next[0];
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_noise.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("noise word %0d arrived with nothing expected", m_axis_tdata);
				end
			end else begin
				want = expected_noise.pop_front();
				bytes_checked++;
				if (m_axis_tdata !== want) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("noise_value mismatch: expected %0d, got %0d (seed %h)",
							want, m_axis_tdata, noise_seed);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still expected",
				cycles, expected_noise.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	// everything driven and every expected byte back, then let the pipe settle;
	// checked at the falling edge so that the driver's updates have landed
	task automatic wait_idle();
		@(negedge clk);
		while (pixel_queue.size() != 0 || s_axis_tvalid || expected_noise.size() != 0) begin
			@(negedge clk);
		end
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic write_seed(logic [31:0] value);
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		noise_seed = value;
		seeds_used++;
	endtask

	function automatic pixel_t pix(int unsigned x, int unsigned z);
		pixel_t p;
		p.x = COORD_W'(x);
		p.z = COORD_W'(z);
		return p;
	endfunction

	// append one pixel to the driver's queue
	function automatic void add_pixel(pixel_t p);
		pixel_queue = {pixel_queue, p};
	endfunction

	// coordinate biased toward grid edges and cell boundaries
	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) != 0) ? 9'd511 : 9'd0;
			// just around a cell edge of the highest octave, which includes every edge of the lowest octave
			1: return COORD_W'(($urandom_range(1, 14) * 512 / 15 + $urandom_range(0, 2)) % 512);
			default: return COORD_W'($urandom_range(0, 511));
		endcase
	endfunction

	task automatic push_random(int unsigned count);
		pixel_t p;
		repeat (count) begin
			p.x = pick_coord();
			p.z = pick_coord();
			add_pixel(p);
		end
	endtask

	logic [31:0] seed_plan[5];

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pixels under the reset seed (zero)
		add_pixel(pix(0, 0));
		add_pixel(pix(511, 511));
		add_pixel(pix(0, 511));
		add_pixel(pix(511, 0));
		add_pixel(pix(1, 1));
		add_pixel(pix(170, 171));   // octave 3 cell edge, both sides
		add_pixel(pix(171, 170));
		add_pixel(pix(73, 74));     // octave 7 cell edge
		add_pixel(pix(34, 35));     // octave 15 cell edge
		add_pixel(pix(256, 256));   // fraction one half in every octave
		add_pixel(pix(255, 257));
		add_pixel(pix(341, 342));
		add_pixel(pix(9'h155, 9'h0AA));
		add_pixel(pix(9'h0AA, 9'h155));
		add_pixel(pix(510, 2));
		add_pixel(pix(2, 510));

		// seeds: all ones wraps seed+1 and seed+2, then a random one, MSB only,
		// all ones minus one, and back to zero
		seed_plan[0] = 32'hFFFF_FFFF;
		seed_plan[1] = $urandom;
		seed_plan[2] = 32'h8000_0000;
		seed_plan[3] = 32'hFFFF_FFFE;
		seed_plan[4] = 32'h0000_0000;

		foreach (seed_plan[i]) begin
			write_seed(seed_plan[i]);
			add_pixel(pix(0, 0));
			add_pixel(pix(511, 511));
			push_random(RANDOM_ITEMS / 2);
			if (i == 1) begin
				// hold the sender until the pipe has drained completely
				wait_idle();
			end
			push_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
		end

		wait_idle();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (expected_noise.size() != 0) begin
			errors++;
		end

		$display("covered %0d pixels over %0d seeds after the reset seed, %0d bytes checked",
			pixels_sent, seeds_used, bytes_checked);
		$display("%0d errors in %0d cycles", errors, cycles);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
